FILE: sv/wrmm_pkg.sv
// Shared types and default sizes for the windowed running min/max tracker.
package wrmm_pkg;

    localparam int NUM_SAMPLES_DEF = 3;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef struct packed {
        logic load;        // capture input word
        logic fill_all;    // restart: every slot takes the new sample
        logic fill_k;      // overwrite slots from scan index onward
        logic start_scan;  // scan index to 1, shift count to 0
        logic inc_k;       // next scan index
        logic shift;       // drop expired head, refill tail
        logic out_load;    // slot 0 value to output register
    } dp_cmd_t;

    typedef struct packed {
        logic restart;       // restart condition on captured word
        logic beats_k;       // new value at least as good as slot k
        logic k_last;        // scan index at last slot
        logic head_expired;  // slot 0 expired and shift budget left
    } dp_stat_t;

endpackage

FILE: sv/windowed_running_minmax_top.sv
// Top level of the windowed running min/max tracker.
//
//  channel  direction  handshake                       contents
//  in       to block   in_valid / in_stall             cmd, sample_time, sample_value
//  out      from block out_valid / out_stall           best_value
//  cfg      to block   psel penable pwrite pready      window_length (0x0), track_max (0x4)
//
// A restarting word goes from the check straight to the final step; otherwise one slot is
// compared per cycle in the scan, and one expired head is shifted out per cycle.
// Reset clears the slots, counters, config and handshake state; no clearing pass follows.
// A result waits in the output register while the next word is taken; a stalled
// result holds the controller in its final step until it is taken.
module windowed_running_minmax_top
    import wrmm_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] sample_time,
    input  logic [31:0] sample_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] best_value
);

    dp_cmd_t     dp_cmd;
    dp_stat_t    dp_stat;
    logic [31:0] window_length;
    logic        track_max;

    wrmm_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .window_length (window_length),
        .track_max     (track_max)
    );

    wrmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    wrmm_dp #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .TIME_WIDTH  (TIME_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .window_length (window_length),
        .track_max     (track_max),
        .cmd           (cmd),
        .sample_time   (sample_time),
        .sample_value  (sample_value),
        .best_value    (best_value)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a word is in progress");

    a_fill_on_restart: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.fill_all |-> dp_stat.restart)
        else $error("slots refilled without a restart condition");

    a_shift_on_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.shift |-> dp_stat.head_expired)
        else $error("head shifted out while still inside the window");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!out_valid || !out_stall))
        else $error("pending result overwritten");

endmodule

FILE: sv/wrmm_cfg.sv
// Configuration registers behind the APB-style port.
module wrmm_cfg
    import wrmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] window_length,
    output logic        track_max
);

    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_TRACK_MAX     = 1'b1;

    logic [31:0] window_length_reg, window_length_next;
    logic        track_max_reg, track_max_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        window_length_next = window_length_reg;
        track_max_next     = track_max_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_WINDOW_LENGTH: window_length_next = pwdata;
                REG_TRACK_MAX:     track_max_next     = pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_LENGTH: prdata = window_length_reg;
            REG_TRACK_MAX:     prdata = {31'd0, track_max_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= 32'd0;
            track_max_reg     <= 1'b0;
        end
        else
        begin
            window_length_reg <= window_length_next;
            track_max_reg     <= track_max_next;
        end
    end

    assign window_length = window_length_reg;
    assign track_max     = track_max_reg;

endmodule

FILE: sv/wrmm_dp.sv
// Datapath: captured word, candidate slots, scan and shift counters, output register.
module wrmm_dp
    import wrmm_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     dp_cmd,
    output dp_stat_t    dp_stat,
    input  logic [31:0] window_length,
    input  logic        track_max,
    input  logic        cmd,
    input  logic [31:0] sample_time,
    input  logic [31:0] sample_value,
    output logic [31:0] best_value
);

    localparam int KW = $clog2(NUM_SAMPLES);
    localparam int NW = $clog2(NUM_SAMPLES + 1);
    localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam logic [KW-1:0] K_LAST = KW'(NUM_SAMPLES - 1);
    localparam logic [NW-1:0] N_MAX  = NW'(NUM_SAMPLES);

    logic                   cmd_reg;
    logic [TIME_WIDTH-1:0]  cur_time_reg;
    logic [VALUE_WIDTH-1:0] cur_value_reg;
    logic [TIME_WIDTH-1:0]  slot_time_reg  [NUM_SAMPLES];
    logic [VALUE_WIDTH-1:0] slot_value_reg [NUM_SAMPLES];
    logic [KW-1:0]          k_reg;
    logic [NW-1:0]          n_reg;
    logic [31:0]            best_reg;

    logic [63:0]            time_ext, value_ext, best_ext;

    function automatic logic beats(input logic tmax, input logic [VALUE_WIDTH-1:0] v,
                                   input logic [VALUE_WIDTH-1:0] s);
        return tmax ? (v >= s) : (v <= s);
    endfunction

    function automatic logic expired(input logic [TIME_WIDTH-1:0] now,
                                     input logic [TIME_WIDTH-1:0] then_t,
                                     input logic [31:0] win);
        logic [TIME_WIDTH-1:0] diff;
        diff = now - then_t;
        return CW'(diff) > CW'(win);
    endfunction

    assign time_ext  = 64'(sample_time);
    assign value_ext = 64'(sample_value);
    assign best_ext  = 64'(slot_value_reg[0]);

    assign dp_stat.restart = cmd_reg
        || beats(track_max, cur_value_reg, slot_value_reg[0])
        || expired(cur_time_reg, slot_time_reg[NUM_SAMPLES-1], window_length);
    assign dp_stat.beats_k = beats(track_max, cur_value_reg, slot_value_reg[k_reg]);
    assign dp_stat.k_last  = (k_reg == K_LAST);
    assign dp_stat.head_expired = (n_reg < N_MAX)
        && expired(cur_time_reg, slot_time_reg[0], window_length);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg       <= cmd;
            cur_time_reg  <= time_ext[TIME_WIDTH-1:0];
            cur_value_reg <= value_ext[VALUE_WIDTH-1:0];
        end
        if (dp_cmd.out_load)
        begin
            best_reg <= best_ext[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            n_reg <= '0;
        end
        else if (dp_cmd.start_scan)
        begin
            k_reg <= KW'(1);
            n_reg <= '0;
        end
        else
        begin
            if (dp_cmd.inc_k)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (dp_cmd.shift)
            begin
                n_reg <= n_reg + NW'(1);
            end
        end
    end

    for (genvar j = 0; j < NUM_SAMPLES; j++)
    begin : g_slot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                slot_time_reg[j]  <= '0;
                slot_value_reg[j] <= '0;
            end
            else if (dp_cmd.fill_all || (dp_cmd.fill_k && (KW'(j) >= k_reg)))
            begin
                slot_time_reg[j]  <= cur_time_reg;
                slot_value_reg[j] <= cur_value_reg;
            end
            else if (dp_cmd.shift)
            begin
                if (j == NUM_SAMPLES - 1)
                begin
                    slot_time_reg[j]  <= cur_time_reg;
                    slot_value_reg[j] <= cur_value_reg;
                end
                else
                begin
                    slot_time_reg[j]  <= slot_time_reg[(j + 1) % NUM_SAMPLES];
                    slot_value_reg[j] <= slot_value_reg[(j + 1) % NUM_SAMPLES];
                end
            end
        end
    end

    assign best_value = best_reg;

endmodule

FILE: sv/wrmm_ctrl.sv
// Controller: sequences capture, restart check, slot scan, expiry shifts and result.
module wrmm_ctrl
    import wrmm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EXPIRE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        dp_cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (dp_stat.restart)
                begin
                    dp_cmd.fill_all = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    dp_cmd.start_scan = 1'b1;
                    state_next        = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (dp_stat.beats_k)
                begin
                    dp_cmd.fill_k = 1'b1;
                    state_next    = ST_EXPIRE;
                end
                else if (dp_stat.k_last)
                begin
                    state_next = ST_EXPIRE;
                end
                else
                begin
                    dp_cmd.inc_k = 1'b1;
                end
            end
            ST_EXPIRE:
            begin
                if (dp_stat.head_expired)
                begin
                    dp_cmd.shift = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    dp_cmd.out_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: verif/wrmm_best_checker.sv
// Register map, command codes and the best-value checker for the windowed min/max tracker.
`timescale 1ns / 1ps

package wrmm_tb_pkg;

    localparam logic [2:0] REG_WINDOW  = 3'h0;
    localparam logic [2:0] REG_TRACK   = 3'h4;
    localparam logic       CMD_UPDATE  = 1'b0;
    localparam logic       CMD_RESTART = 1'b1;
    localparam logic       TRACK_MIN   = 1'b0;
    localparam logic       TRACK_MAX   = 1'b1;

endpackage

module wrmm_best_checker
    import wrmm_tb_pkg::*;
#(
    parameter int NUM_SAMPLES = wrmm_pkg::NUM_SAMPLES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] sample_time,
    input  logic [31:0] sample_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] best_value,
    output int          fail_count,
    output int          words_in_flight
);

    logic [31:0] window;
    logic        track_max;
    logic [31:0] slot_t [NUM_SAMPLES];
    logic [31:0] slot_v [NUM_SAMPLES];
    logic [31:0] expected_best [$];
    logic [31:0] want;
    int          fails;

    function automatic logic beats(logic [31:0] v, logic [31:0] s);
        return track_max ? (v >= s) : (v <= s);
    endfunction

    function automatic logic stale(logic [31:0] now, logic [31:0] then);
        logic [31:0] age;
        age = now - then;
        return age > window;
    endfunction

    function void track_sample(logic restart, logic [31:0] t, logic [31:0] v);
        int k;
        int n;
        if (restart || beats(v, slot_v[0]) || stale(t, slot_t[NUM_SAMPLES-1])) begin
            for (int j = 0; j < NUM_SAMPLES; j++)
            begin
                slot_t[j] = t;
                slot_v[j] = v;
            end
        end
        else
        begin
            k = 1;
            while (k < NUM_SAMPLES && !beats(v, slot_v[k]))
                k++;
            for (int j = k; j < NUM_SAMPLES; j++)
            begin
                slot_t[j] = t;
                slot_v[j] = v;
            end
            n = 0;
            while (n < NUM_SAMPLES && stale(t, slot_t[0]))
            begin
                for (int j = 0; j < NUM_SAMPLES - 1; j++)
                begin
                    slot_t[j] = slot_t[j+1];
                    slot_v[j] = slot_v[j+1];
                end
                slot_t[NUM_SAMPLES-1] = t;
                slot_v[NUM_SAMPLES-1] = v;
                n++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window    = '0;
            track_max = TRACK_MIN;
            for (int j = 0; j < NUM_SAMPLES; j++)
            begin
                slot_t[j] = '0;
                slot_v[j] = '0;
            end
            expected_best.delete();
            fails = 0;
            fail_count      <= 0;
            words_in_flight <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_best.size() == 0)
                begin
                    $display("%0t: best_value expected none, got %h", $time, best_value);
                    fails++;
                end
                else
                begin
                    want = expected_best.pop_front();
                    if (best_value !== want)
                    begin
                        $display("%0t: best_value expected %h, got %h",
                                 $time, want, best_value);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    REG_WINDOW: window    = pwdata;
                    REG_TRACK:  track_max = pwdata[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                track_sample(cmd == CMD_RESTART, sample_time, sample_value);
                expected_best.push_back(slot_v[0]);
            end
            fail_count      <= fails;
            words_in_flight <= expected_best.size();
        end
    end

endmodule

FILE: verif/tb.sv
// Stimulus, idling and verdict for the windowed running min/max tracker.
`timescale 1ns / 1ps

module tb;
    import wrmm_pkg::*;
    import wrmm_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE         = 2 * NUM_SAMPLES_DEF + 3 + 4;
    localparam int PHASE_WORDS    = 125;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [31:0] sample_time;
    logic [31:0] sample_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] best_value;

    int fail_count;
    int words_in_flight;
    int idle_cycles = 0;
    int words_sent = 0;
    int restarts_sent = 0;
    int settings_done = 0;
    bit quiet = 1'b0;
    bit calm = 1'b0;

    windowed_running_minmax_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .sample_time  (sample_time),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .best_value   (best_value)
    );

    wrmm_best_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .sample_time     (sample_time),
        .sample_value    (sample_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .best_value      (best_value),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output side back-pressure
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20))
                @(posedge clk);
            if (!quiet)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [31:0] w, logic track);
        logic [31:0] junk;
        junk    = $urandom;
        junk[0] = track;
        reg_write(REG_WINDOW, w);
        reg_write(REG_TRACK, junk);
        settings_done++;
    endtask

    task automatic send_word(logic c, logic [31:0] t, logic [31:0] v);
        in_valid     <= 1'b1;
        cmd          <= c;
        sample_time  <= t;
        sample_value <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        if (c == CMD_RESTART)
            restarts_sent++;
    endtask

    task automatic maybe_gap();
        if (!quiet && !calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(logic [31:0] w, logic track, bit calm_phase);
        int unsigned roll;
        logic [31:0] now;
        logic [31:0] base;
        logic [31:0] step;
        logic [31:0] t;
        logic [31:0] v;
        logic        c;
        drain();
        configure(w, track);
        calm = calm_phase;
        now  = $urandom;
        base = $urandom;
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                step = $urandom_range(0, w / 4 + 1);
            else if (roll < 90)
                step = $urandom_range(0, w) + $urandom_range(0, w / 2 + 1);
            else
                step = $urandom;
            if ($urandom_range(0, 19) == 0)
                t = $urandom;
            else
            begin
                now = now + step;
                t   = now;
            end
            if ($urandom_range(0, 32) == 0)
                base = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 60)
                v = base + $urandom_range(0, 15);
            else if (roll < 65)
                v = roll[0] ? 32'hFFFF_FFFF : 32'h0;
            else
                v = $urandom;
            c = ($urandom_range(0, 19) == 0) ? CMD_RESTART : CMD_UPDATE;
            send_word(c, t, v);
            maybe_gap();
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= REG_WINDOW;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        cmd          <= CMD_UPDATE;
        sample_time  <= '0;
        sample_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset contents used as ordinary samples, zero window
        send_word(CMD_UPDATE, 32'd0, 32'd5);
        send_word(CMD_UPDATE, 32'd0, 32'd0);
        send_word(CMD_UPDATE, 32'd1, 32'd7);

        drain();
        configure(32'd10, TRACK_MIN);
        send_word(CMD_RESTART, 32'd100, 32'd50);
        send_word(CMD_UPDATE,  32'd102, 32'd60);
        send_word(CMD_UPDATE,  32'd104, 32'd55);
        send_word(CMD_UPDATE,  32'd105, 32'd55);
        send_word(CMD_UPDATE,  32'd112, 32'd70);
        send_word(CMD_UPDATE,  32'd130, 32'd80);
        // timestamps wrapping through zero
        send_word(CMD_RESTART, 32'hFFFF_FFFA, 32'd40);
        send_word(CMD_UPDATE,  32'h0000_0002, 32'd45);
        send_word(CMD_UPDATE,  32'h0000_0007, 32'd46);
        send_word(CMD_UPDATE,  32'h0000_0008, 32'hFFFF_FFFF);

        drain();
        configure(32'hFFFF_FFFF, TRACK_MAX);
        send_word(CMD_RESTART, 32'd0, 32'd0);
        send_word(CMD_UPDATE,  32'd5, 32'hFFFF_FFFF);
        send_word(CMD_UPDATE,  32'd6, 32'd100);
        send_word(CMD_UPDATE,  32'd7, 32'd200);
        send_word(CMD_UPDATE,  32'd8, 32'd200);
        send_word(CMD_UPDATE,  32'hFFFF_FFFF, 32'd0);
        send_word(CMD_UPDATE,  32'h8000_0000, 32'h5555_5555);

        run_phase(32'd0,         TRACK_MIN, 1'b0);
        run_phase(32'hFFFF_FFFF, TRACK_MAX, 1'b0);
        run_phase(32'd16,        TRACK_MIN, 1'b1);
        run_phase(32'd16,        TRACK_MAX, 1'b0);
        run_phase(32'd1000,      TRACK_MIN, 1'b0);
        run_phase($urandom,      TRACK_MAX, 1'b0);
        run_phase($urandom_range(1, 200), TRACK_MIN, 1'b0);
        quiet = 1'b1;
        run_phase(32'd50,        TRACK_MAX, 1'b0);
        drain();

        $display("Sent %0d words (%0d restarts) under %0d register settings.",
                 words_sent, restarts_sent, settings_done);
        $display("Min and max tracking, windows from zero to all ones, with wrap and ties.");
        if (fail_count == 0 && words_in_flight == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
